### hw/rtl/tps_pkg.sv
// Shared types and constants for the top-up pump sequencer.
package tps_pkg;

    localparam int COUNT_WIDTH   = 32;
    localparam int REG_WIDTH     = 32;
    localparam int CMP_WIDTH     = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;
    localparam int CMD_WIDTH     = 2;
    localparam int S_TDATA_WIDTH = 8;
    localparam int M_TDATA_WIDTH = 8;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [REG_WIDTH-1:0] START_DELAY_RESET = REG_WIDTH'(5000);
    localparam logic [REG_WIDTH-1:0] MAX_RUNTIME_RESET = REG_WIDTH'(60000);

    localparam logic CFG_START_DELAY = 1'b0;
    localparam logic CFG_MAX_RUNTIME = 1'b1;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_TICK    = 2'd0,
        CMD_SERVICE = 2'd1,
        CMD_PERMIT  = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_SERVICE,
        OP_PERMIT,
        OP_CLEAR
    } op_kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_WAITING = 3'd1,
        MODE_PUMPING = 3'd2,
        MODE_BLOCKED = 3'd3,
        MODE_LOCKOUT = 3'd4
    } mode_t;

    typedef struct packed {
        op_kind_t kind;
        logic     low_water;
        logic     flag_value;
    } req_t;

    typedef struct packed {
        logic  locked;
        logic  permit_active;
        logic  service_active;
        mode_t machine_state;
        logic  pump_on;
    } result_t;

endpackage

### hw/rtl/tps_front.sv
// Front stage: accepts requests and classifies the command into an operation.
module tps_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tps_pkg::CMD_WIDTH-1:0]     s_tuser,  // [1:0] command
    input  logic [tps_pkg::S_TDATA_WIDTH-1:0] s_tdata,  // [0] low_water, [1] flag_value
    output logic                              req_valid,
    input  logic                              req_ready,
    output tps_pkg::req_t                     req
);
    import tps_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    req_t     req_reg;
    req_t     req_next;
    op_kind_t kind;

    always_comb begin
        unique case (cmd_t'(s_tuser))
            CMD_TICK:    kind = OP_TICK;
            CMD_SERVICE: kind = OP_SERVICE;
            CMD_PERMIT:  kind = OP_PERMIT;
            CMD_CLEAR:   kind = OP_CLEAR;
            default:     kind = OP_CLEAR;
        endcase
    end

    assign s_tready = !valid_reg || req_ready;

    always_comb begin
        valid_next = valid_reg;
        req_next   = req_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
            req_next   = '{kind: kind, low_water: s_tdata[0], flag_value: s_tdata[1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        req_reg <= req_next;
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

### hw/rtl/tps_queue.sv
// Short request queue between the front and back stages.
module tps_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  tps_pkg::req_t in_req,
    output logic          out_valid,
    input  logic          out_ready,
    output tps_pkg::req_t out_req
);
    import tps_pkg::*;

    req_t                  entry_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg;
    logic [QPTR_WIDTH-1:0] wr_ptr_next;
    logic [QPTR_WIDTH-1:0] rd_ptr_reg;
    logic [QPTR_WIDTH-1:0] rd_ptr_next;
    logic [QCNT_WIDTH-1:0] count_reg;
    logic [QCNT_WIDTH-1:0] count_next;
    logic                  push;
    logic                  pop;

    assign in_ready  = (count_reg != QCNT_WIDTH'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_req   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

### hw/rtl/tps_back.sv
// Back stage: runs the pump state machine and holds the result register.
module tps_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [tps_pkg::REG_WIDTH-1:0]     cfg_wdata,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  tps_pkg::req_t                     req,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tps_pkg::M_TDATA_WIDTH-1:0] m_tdata
);
    import tps_pkg::*;

    logic [REG_WIDTH-1:0]   start_delay_reg;
    logic [REG_WIDTH-1:0]   max_runtime_reg;
    mode_t                  state_reg;
    mode_t                  state_next;
    logic [COUNT_WIDTH-1:0] elapsed_reg;
    logic [COUNT_WIDTH-1:0] elapsed_next;
    logic [COUNT_WIDTH-1:0] elapsed_inc;
    logic                   service_reg;
    logic                   service_next;
    logic                   permit_reg;
    logic                   permit_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    result_t                result_reg;
    result_t                result_next;
    logic                   take;
    logic                   start_due;
    logic                   runtime_due;

    assign req_ready = !out_valid_reg || m_tready;
    assign take      = req_valid && req_ready;

    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign start_due   = CMP_WIDTH'(elapsed_inc) >= CMP_WIDTH'(start_delay_reg);
    assign runtime_due = CMP_WIDTH'(elapsed_inc) >= CMP_WIDTH'(max_runtime_reg);

    always_comb begin
        mode_t tick_state;
        tick_state   = state_reg;
        state_next   = state_reg;
        elapsed_next = elapsed_reg;
        service_next = service_reg;
        permit_next  = permit_reg;
        if (take) begin
            unique case (req.kind)
                OP_TICK: begin
                    elapsed_next = elapsed_inc;
                    if (service_reg) begin
                        state_next = state_reg;
                    end else if (!permit_reg) begin
                        if (state_reg != MODE_LOCKOUT && state_reg != MODE_BLOCKED) begin
                            state_next   = MODE_BLOCKED;
                            elapsed_next = '0;
                        end
                    end else begin
                        if (state_reg == MODE_BLOCKED) begin
                            tick_state   = MODE_IDLE;
                            state_next   = MODE_IDLE;
                            elapsed_next = '0;
                        end
                        unique case (tick_state)
                            MODE_IDLE: begin
                                if (req.low_water) begin
                                    state_next   = MODE_WAITING;
                                    elapsed_next = '0;
                                end
                            end
                            MODE_WAITING: begin
                                if (!req.low_water) begin
                                    state_next   = MODE_IDLE;
                                    elapsed_next = '0;
                                end else if (start_due) begin
                                    state_next   = MODE_PUMPING;
                                    elapsed_next = '0;
                                end
                            end
                            MODE_PUMPING: begin
                                if (!req.low_water) begin
                                    state_next   = MODE_IDLE;
                                    elapsed_next = '0;
                                end else if (runtime_due) begin
                                    state_next   = MODE_LOCKOUT;
                                    elapsed_next = '0;
                                end
                            end
                            default: begin
                                state_next = state_reg;
                            end
                        endcase
                    end
                end
                OP_SERVICE: begin
                    if (service_reg != req.flag_value) begin
                        service_next = req.flag_value;
                        if (state_reg != MODE_LOCKOUT) begin
                            state_next   = permit_reg ? MODE_IDLE : MODE_BLOCKED;
                            elapsed_next = '0;
                        end
                    end
                end
                OP_PERMIT: begin
                    if (permit_reg != req.flag_value) begin
                        permit_next = req.flag_value;
                        if (!req.flag_value && state_reg != MODE_LOCKOUT) begin
                            state_next   = MODE_BLOCKED;
                            elapsed_next = '0;
                        end
                    end
                end
                OP_CLEAR: begin
                    state_next   = permit_reg ? MODE_IDLE : MODE_BLOCKED;
                    elapsed_next = '0;
                end
                default: begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (req_ready) begin
            out_valid_next = req_valid;
            result_next    = '{locked:         (state_next == MODE_LOCKOUT),
                               permit_active:  permit_next,
                               service_active: service_next,
                               machine_state:  state_next,
                               pump_on:        (state_next == MODE_PUMPING)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_delay_reg <= START_DELAY_RESET;
            max_runtime_reg <= MAX_RUNTIME_RESET;
            state_reg       <= MODE_IDLE;
            elapsed_reg     <= '0;
            service_reg     <= 1'b0;
            permit_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == CFG_START_DELAY) begin
                start_delay_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == CFG_MAX_RUNTIME) begin
                max_runtime_reg <= cfg_wdata;
            end
            state_reg     <= state_next;
            elapsed_reg   <= elapsed_next;
            service_reg   <= service_next;
            permit_reg    <= permit_next;
            out_valid_reg <= out_valid_next;
        end
        result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_WIDTH'(result_reg);

endmodule

### hw/rtl/topup_pump_sequencer.sv
// Top level of the top-up pump sequencer.
//
//   Group   Direction  Contents
//   s_*     in         request: command in tuser, sensor and flag bits in tdata
//   m_*     out        result: pump drive, state and flags in tdata
//   cfg_*   in         register write: index 0 start delay, 1 maximum runtime
//
// One request is taken per cycle unless a stalled result fills the queue; each result
// passes from its request through the front register, the queue and the result register.
// Reset is synchronous and clears the state machine, counters and queue.
// A stalled result holds in its register while the queue keeps taking requests until it is full.
module topup_pump_sequencer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tps_pkg::CMD_WIDTH-1:0]     s_tuser,  // [1:0] command
    input  logic [tps_pkg::S_TDATA_WIDTH-1:0] s_tdata,  // [0] low_water, [1] flag_value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] pump_on, [3:1] machine_state, [4] service_active, [5] permit_active, [6] locked
    output logic [tps_pkg::M_TDATA_WIDTH-1:0] m_tdata,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [tps_pkg::REG_WIDTH-1:0]     cfg_wdata
);
    import tps_pkg::*;

    logic front_valid;
    logic front_ready;
    req_t front_req;
    logic back_valid;
    logic back_ready;
    req_t back_req;

    tps_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .req_valid (front_valid),
        .req_ready (front_ready),
        .req       (front_req)
    );

    tps_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_req    (front_req),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_req   (back_req)
    );

    tps_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_valid (back_valid),
        .req_ready (back_ready),
        .req       (back_req),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### verif/topup_pump_sequencer_tb.sv
// Self-checking testbench for the top-up pump sequencer: directed and random requests, all phases.
`timescale 1ns / 1ps

module topup_pump_sequencer_tb;
    import tps_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 250;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [CMD_WIDTH-1:0]     s_tuser = CMD_TICK;
    logic [S_TDATA_WIDTH-1:0] s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_TDATA_WIDTH-1:0] m_tdata;
    logic                     cfg_we = 1'b0;
    logic                     cfg_index = CFG_START_DELAY;
    logic [REG_WIDTH-1:0]     cfg_wdata = '0;

    // Predictor state of the sequencer and its registers.
    mode_t                  seq_mode;
    logic [COUNT_WIDTH-1:0] seq_ticks;
    logic                   seq_service;
    logic                   seq_permit;
    logic [REG_WIDTH-1:0]   reg_start_delay;
    logic [REG_WIDTH-1:0]   reg_max_runtime;

    result_t pending_status[$];
    result_t observed_status;
    result_t wanted_status;

    int  sender_idle_pct = 0;
    int  receiver_stall_pct = 0;
    int  error_count = 0;
    int  requests_sent = 0;
    int  results_checked = 0;
    int  lockouts_seen = 0;
    int  cycle_count = 0;
    logic water_low = 1'b1;

    topup_pump_sequencer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[topup_pump_sequencer] ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            observed_status = result_t'(m_tdata[6:0]);
            if (pending_status.size() == 0) begin
                $error("unexpected result, tdata %h", m_tdata);
                error_count++;
            end else begin
                wanted_status = pending_status.pop_front();
                results_checked++;
                if (observed_status.pump_on !== wanted_status.pump_on) begin
                    $error("pump_on: expected %0d, got %0d",
                           wanted_status.pump_on, observed_status.pump_on);
                    error_count++;
                end
                if (observed_status.machine_state !== wanted_status.machine_state) begin
                    $error("machine_state: expected %0d, got %0d",
                           wanted_status.machine_state, observed_status.machine_state);
                    error_count++;
                end
                if (observed_status.service_active !== wanted_status.service_active) begin
                    $error("service_active: expected %0d, got %0d",
                           wanted_status.service_active, observed_status.service_active);
                    error_count++;
                end
                if (observed_status.permit_active !== wanted_status.permit_active) begin
                    $error("permit_active: expected %0d, got %0d",
                           wanted_status.permit_active, observed_status.permit_active);
                    error_count++;
                end
                if (observed_status.locked !== wanted_status.locked) begin
                    $error("locked: expected %0d, got %0d",
                           wanted_status.locked, observed_status.locked);
                    error_count++;
                end
            end
        end
    end

    function automatic void enter_mode(mode_t next_mode);
        seq_mode = next_mode;
        seq_ticks = '0;
    endfunction

    function automatic result_t advance_sequencer(cmd_t cmd, logic low, logic flag);
        result_t status;
        case (cmd)
            CMD_TICK: begin
                if (seq_ticks != {COUNT_WIDTH{1'b1}})
                    seq_ticks = seq_ticks + 1'b1;
                if (!seq_service) begin
                    if (!seq_permit) begin
                        if (seq_mode != MODE_LOCKOUT && seq_mode != MODE_BLOCKED)
                            enter_mode(MODE_BLOCKED);
                    end else begin
                        if (seq_mode == MODE_BLOCKED)
                            enter_mode(MODE_IDLE);
                        case (seq_mode)
                            MODE_IDLE: begin
                                if (low)
                                    enter_mode(MODE_WAITING);
                            end
                            MODE_WAITING: begin
                                if (!low)
                                    enter_mode(MODE_IDLE);
                                else if (seq_ticks >= reg_start_delay)
                                    enter_mode(MODE_PUMPING);
                            end
                            MODE_PUMPING: begin
                                if (!low)
                                    enter_mode(MODE_IDLE);
                                else if (seq_ticks >= reg_max_runtime)
                                    enter_mode(MODE_LOCKOUT);
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            CMD_SERVICE: begin
                if (seq_service != flag) begin
                    seq_service = flag;
                    if (seq_mode != MODE_LOCKOUT)
                        enter_mode(seq_permit ? MODE_IDLE : MODE_BLOCKED);
                end
            end
            CMD_PERMIT: begin
                if (seq_permit != flag) begin
                    seq_permit = flag;
                    if (!seq_permit && seq_mode != MODE_LOCKOUT)
                        enter_mode(MODE_BLOCKED);
                end
            end
            default: begin
                enter_mode(seq_permit ? MODE_IDLE : MODE_BLOCKED);
            end
        endcase
        status.pump_on = (seq_mode == MODE_PUMPING);
        status.machine_state = seq_mode;
        status.service_active = seq_service;
        status.permit_active = seq_permit;
        status.locked = (seq_mode == MODE_LOCKOUT);
        return status;
    endfunction

    task automatic send_request(cmd_t cmd, logic low, logic flag);
        result_t status;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= S_TDATA_WIDTH'({flag, low});
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        status = advance_sequencer(cmd, low, flag);
        if (status.locked)
            lockouts_seen++;
        pending_status.push_back(status);
        requests_sent++;
    endtask

    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_registers(logic [REG_WIDTH-1:0] delay, logic [REG_WIDTH-1:0] runtime);
        wait_until_idle();
        cfg_we <= 1'b1;
        cfg_index <= CFG_START_DELAY;
        cfg_wdata <= delay;
        @(posedge aclk);
        cfg_index <= CFG_MAX_RUNTIME;
        cfg_wdata <= runtime;
        @(posedge aclk);
        cfg_we <= 1'b0;
        reg_start_delay = delay;
        reg_max_runtime = runtime;
    endtask

    task automatic run_random_requests(int count);
        int   pick;
        cmd_t cmd;
        logic low;
        logic flag;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 7) == 0)
                water_low = ~water_low;
            low = ($urandom_range(0, 19) == 0) ? 1'($urandom) : water_low;
            flag = 1'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                cmd = CMD_TICK;
            end else if (pick < 85) begin
                cmd = CMD_PERMIT;
                flag = ($urandom_range(0, 9) < 7);
            end else if (pick < 91) begin
                cmd = CMD_SERVICE;
                flag = ($urandom_range(0, 9) < 4);
            end else begin
                cmd = CMD_CLEAR;
            end
            send_request(cmd, low, flag);
        end
    endtask

    task automatic test_directed_sequences();
        // Reset values: no permit blocks, and the start delay is far from zero.
        send_request(CMD_TICK, 1'b1, 1'b0);
        send_request(CMD_PERMIT, 1'b0, 1'b1);
        send_request(CMD_PERMIT, 1'b1, 1'b1);
        send_request(CMD_TICK, 1'b1, 1'b1);
        send_request(CMD_TICK, 1'b1, 1'b0);
        send_request(CMD_TICK, 1'b0, 1'b0);
        // Zero delay and a one-tick runtime reach lockout quickly.
        set_registers('0, REG_WIDTH'(1));
        send_request(CMD_TICK, 1'b1, 1'b0);
        send_request(CMD_TICK, 1'b1, 1'b0);
        send_request(CMD_TICK, 1'b1, 1'b1);
        send_request(CMD_TICK, 1'b0, 1'b0);
        send_request(CMD_SERVICE, 1'b0, 1'b1);
        send_request(CMD_TICK, 1'b1, 1'b0);
        send_request(CMD_CLEAR, 1'b1, 1'b1);
        send_request(CMD_SERVICE, 1'b1, 1'b0);
        send_request(CMD_TICK, 1'b1, 1'b0);
        send_request(CMD_CLEAR, 1'b0, 1'b0);
        send_request(CMD_PERMIT, 1'b1, 1'b0);
        send_request(CMD_CLEAR, 1'b1, 1'b1);
        send_request(CMD_TICK, 1'b1, 1'b0);
        // Maximum delay never starts the pump; zero runtime locks out at once.
        set_registers('1, '0);
        send_request(CMD_PERMIT, 1'b0, 1'b1);
        send_request(CMD_TICK, 1'b1, 1'b0);
        send_request(CMD_TICK, 1'b1, 1'b1);
        set_registers('0, '0);
        send_request(CMD_TICK, 1'b1, 1'b0);
        send_request(CMD_TICK, 1'b1, 1'b0);
        send_request(CMD_TICK, 1'b0, 1'b0);
    endtask

    task automatic test_streaming_without_gaps();
        set_registers(REG_WIDTH'(3), REG_WIDTH'(6));
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        run_random_requests(RANDOM_PER_PHASE);
    endtask

    task automatic test_sender_gaps();
        set_registers('0, '1);
        sender_idle_pct = 49;
        receiver_stall_pct = 0;
        run_random_requests(RANDOM_PER_PHASE);
    endtask

    task automatic test_receiver_stalls();
        set_registers(REG_WIDTH'(1), REG_WIDTH'(4));
        sender_idle_pct = 0;
        receiver_stall_pct = 49;
        run_random_requests(RANDOM_PER_PHASE);
    endtask

    task automatic test_light_gaps_both_sides();
        set_registers(REG_WIDTH'(2), REG_WIDTH'(10));
        sender_idle_pct = 7;
        receiver_stall_pct = 7;
        run_random_requests(RANDOM_PER_PHASE);
    endtask

    initial begin
        seq_mode = MODE_IDLE;
        seq_ticks = '0;
        seq_service = 1'b0;
        seq_permit = 1'b0;
        reg_start_delay = START_DELAY_RESET;
        reg_max_runtime = MAX_RUNTIME_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_sequences();
        test_streaming_without_gaps();
        test_sender_gaps();
        test_receiver_stalls();
        test_light_gaps_both_sides();
        wait_until_idle();

        $display("Checked %0d results for %0d requests over eight register settings.",
                 results_checked, requests_sent);
        $display("Idle and stall phases included; %0d results showed lockout.", lockouts_seen);
        if (error_count == 0) begin
            $display("[topup_pump_sequencer] OK");
        end else begin
            $display("[topup_pump_sequencer] ERROR");
        end
        $finish;
    end

endmodule
